@@ rtl/core/lbrw_pkg.sv @@
// Package for the longest bounded-range window block.
// Holds default sizes, field widths and the control struct of the cell row.
// No dependencies.
package lbrw_pkg;

  // Default store depth and sample width.
  localparam int DEFAULT_WINDOW_DEPTH = 1024;
  localparam int DEFAULT_SAMPLE_BITS  = 32;

  // Fixed widths of the register and of the length fields.
  localparam int LIMIT_BITS     = 32;
  localparam int FIELD_LEN_BITS = 11;

  // Commands broadcast to every cell of the row.
  typedef struct packed {
    logic append;  // add the held sample at the window end
    logic shift;   // each cell but the top takes its upper neighbor's contents
  } cell_ctrl_t;

endpackage

@@ rtl/core/lbrw_in_if.sv @@
// Sample channel of the longest bounded-range window block.
// Carries valid, ready, one sample and its last flag. Depends on lbrw_pkg.
interface lbrw_in_if #(
  parameter int SAMPLE_BITS = lbrw_pkg::DEFAULT_SAMPLE_BITS
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          last;

  modport source (output valid, output sample, output last, input ready);
  modport sink (input valid, input sample, input last, output ready);
endinterface

@@ rtl/core/lbrw_out_if.sv @@
// Result channel of the longest bounded-range window block.
// Carries valid, ready and the four result fields. Depends on lbrw_pkg.
interface lbrw_out_if;
  logic                                valid;
  logic                                ready;
  logic [lbrw_pkg::FIELD_LEN_BITS-1:0] window_length;
  logic [lbrw_pkg::FIELD_LEN_BITS-1:0] best_length;
  logic                                capped;
  logic                                is_final;

  modport source (
    output valid, output window_length, output best_length,
    output capped, output is_final, input ready
  );
  modport sink (
    input valid, input window_length, input best_length,
    input capped, input is_final, output ready
  );
endinterface

@@ rtl/core/lbrw_cell.sv @@
// One cell of the window row: the max and min of its sample and all newer ones.
// Cell 0 holds the oldest sample of the window. Depends on lbrw_pkg.
module lbrw_cell #(
  parameter int INDEX        = 0,
  parameter int WINDOW_DEPTH = lbrw_pkg::DEFAULT_WINDOW_DEPTH,
  parameter int SAMPLE_BITS  = lbrw_pkg::DEFAULT_SAMPLE_BITS
) (
  input  logic                                  clk,
  input  lbrw_pkg::cell_ctrl_t                  ctrl,
  input  logic [$clog2(WINDOW_DEPTH+1)-1:0]     length,
  input  logic signed [SAMPLE_BITS-1:0]         v,
  input  logic signed [SAMPLE_BITS-1:0]         nb_hi,
  input  logic signed [SAMPLE_BITS-1:0]         nb_lo,
  output logic signed [SAMPLE_BITS-1:0]         hi,
  output logic signed [SAMPLE_BITS-1:0]         lo
);
  localparam int LEN_W = $clog2(WINDOW_DEPTH+1);
  localparam logic [LEN_W-1:0] MY_INDEX = LEN_W'(INDEX);

  // A shift moves the window down by one cell; an append starts a new
  // entry at the window end and folds the sample into every older entry.
  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      hi <= nb_hi;
      lo <= nb_lo;
    end else if (ctrl.append) begin
      if (MY_INDEX == length) begin
        hi <= v;
        lo <= v;
      end else if (MY_INDEX < length) begin
        if (v > hi) hi <= v;
        if (v < lo) lo <= v;
      end
    end
  end
endmodule

@@ rtl/core/lbrw_chain.sv @@
// Row of window cells and the span test on the oldest cell.
// Depends on lbrw_pkg and lbrw_cell.
module lbrw_chain #(
  parameter int WINDOW_DEPTH = lbrw_pkg::DEFAULT_WINDOW_DEPTH,
  parameter int SAMPLE_BITS  = lbrw_pkg::DEFAULT_SAMPLE_BITS
) (
  input  logic                                  clk,
  input  lbrw_pkg::cell_ctrl_t                  ctrl,
  input  logic [$clog2(WINDOW_DEPTH+1)-1:0]     length,
  input  logic signed [SAMPLE_BITS-1:0]         v,
  input  logic [lbrw_pkg::LIMIT_BITS-1:0]       limit,
  output logic                                  over
);
  localparam int SPAN_W = (SAMPLE_BITS + 1 > lbrw_pkg::LIMIT_BITS + 1) ?
                          SAMPLE_BITS + 1 : lbrw_pkg::LIMIT_BITS + 1;

  logic signed [SAMPLE_BITS-1:0] hi_a [WINDOW_DEPTH];
  logic signed [SAMPLE_BITS-1:0] lo_a [WINDOW_DEPTH];

  // Each cell takes its upper neighbor on a shift; the top cell keeps its own.
  for (genvar k = 0; k < WINDOW_DEPTH; k++) begin : g_cell
    logic signed [SAMPLE_BITS-1:0] nb_hi, nb_lo;
    if (k == WINDOW_DEPTH - 1) begin : g_top
      assign nb_hi = hi_a[k];
      assign nb_lo = lo_a[k];
    end else begin : g_mid
      assign nb_hi = hi_a[k+1];
      assign nb_lo = lo_a[k+1];
    end
    lbrw_cell #(
      .INDEX        (k),
      .WINDOW_DEPTH (WINDOW_DEPTH),
      .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_cell (
      .clk    (clk),
      .ctrl   (ctrl),
      .length (length),
      .v      (v),
      .nb_hi  (nb_hi),
      .nb_lo  (nb_lo),
      .hi     (hi_a[k]),
      .lo     (lo_a[k])
    );
  end

  // Cell 0 covers the whole window, so its max minus min is the span.
  // The difference is one bit wider than the wider of a sample and the limit, and never negative.
  logic signed [SPAN_W-1:0] hi_w, lo_w, span_w;
  logic        [SPAN_W-1:0] limit_w;

  assign hi_w    = SPAN_W'(hi_a[0]);
  assign lo_w    = SPAN_W'(lo_a[0]);
  assign span_w  = hi_w - lo_w;
  assign limit_w = SPAN_W'(limit);
  assign over    = $unsigned(span_w) > limit_w;
endmodule

@@ rtl/core/longest_bounded_range_window.sv @@
// Top level of the longest bounded-range window block: sequencer and result register.
// Depends on lbrw_pkg, lbrw_in_if, lbrw_out_if and lbrw_chain.
//
//   channel   direction  transfer condition    payload
//   items     in         valid && ready        sample, last
//   results   out        valid && ready        window_length, best_length, capped, is_final
//   cfg       in         cfg_we (no handshake) cfg_wdata -> span_limit
//
// An item is taken from idle, appended, then shrunk one sample at a time from the window
// front; every sample is dropped at most once. The cell row moves the window by one
// cell a cycle while shrinking, and the result then waits for a free result register.
// A new item is taken once the previous result sits in the output register,
// even while that result is stalled; a stalled result holds back only the next one.
// rst is synchronous; the sample cells need no clearing pass after reset.
module longest_bounded_range_window #(
  parameter int WINDOW_DEPTH = lbrw_pkg::DEFAULT_WINDOW_DEPTH,
  parameter int SAMPLE_BITS  = lbrw_pkg::DEFAULT_SAMPLE_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  lbrw_in_if.sink                         items,
  lbrw_out_if.source                      results,
  input  logic                            cfg_we,
  input  logic [lbrw_pkg::LIMIT_BITS-1:0] cfg_wdata
);
  localparam int LEN_W = $clog2(WINDOW_DEPTH+1);
  localparam int FLW   = lbrw_pkg::FIELD_LEN_BITS;
  localparam logic [LEN_W-1:0] FULL_LEN = LEN_W'(WINDOW_DEPTH);
  localparam logic [LEN_W-1:0] ONE_LEN  = LEN_W'(1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_APPEND,
    S_SHRINK
  } state_t;

  state_t                          state;
  logic [LEN_W-1:0]                length;
  logic [LEN_W-1:0]                best;
  logic [lbrw_pkg::LIMIT_BITS-1:0] limit;
  logic signed [SAMPLE_BITS-1:0]   v_q;
  logic                            last_q;
  logic                            capped_q;
  logic                            out_valid;
  logic [FLW-1:0]                  out_win;
  logic [FLW-1:0]                  out_best;
  logic                            out_capped;
  logic                            out_final;

  lbrw_pkg::cell_ctrl_t ctrl;
  logic                 over;
  logic                 accept;
  logic                 full;
  logic                 shrink_go;
  logic                 emit;
  logic [LEN_W-1:0]     best_next;
  logic [LEN_W+FLW-1:0] len_ext;
  logic [LEN_W+FLW-1:0] best_ext;

  // Cell row with the span test.
  lbrw_chain #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_chain (
    .clk    (clk),
    .ctrl   (ctrl),
    .length (length),
    .v      (v_q),
    .limit  (limit),
    .over   (over)
  );

  // Handshake and step decisions.
  assign items.ready = (state == S_IDLE);
  assign accept      = items.valid && items.ready;
  assign full        = (length == FULL_LEN);
  assign shrink_go   = (state == S_SHRINK) && (length > ONE_LEN) && over;
  assign emit        = (state == S_SHRINK) && !shrink_go &&
                       (!out_valid || results.ready);
  assign best_next   = (length > best) ? length : best;

  // A full window drops its oldest sample in the transfer cycle.
  assign ctrl = '{append: (state == S_APPEND), shift: (accept && full) || shrink_go};

  // Lengths are reported in the low bits of the fixed-width fields.
  assign len_ext  = {{FLW{1'b0}}, length};
  assign best_ext = {{FLW{1'b0}}, best_next};

  // Sequencer, lengths, register and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      length    <= '0;
      best      <= '0;
      limit     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) limit <= cfg_wdata;
      // The result register fills on emit and empties on a result transfer.
      if (emit) out_valid <= 1'b1;
      else if (results.valid && results.ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            v_q      <= items.sample;
            last_q   <= items.last;
            capped_q <= full;
            if (full) length <= length - ONE_LEN;
            state    <= S_APPEND;
          end
        end
        S_APPEND: begin
          length <= length + ONE_LEN;
          state  <= S_SHRINK;
        end
        S_SHRINK: begin
          if (shrink_go) begin
            length <= length - ONE_LEN;
          end else if (emit) begin
            out_win    <= len_ext[FLW-1:0];
            out_best   <= best_ext[FLW-1:0];
            out_capped <= capped_q;
            out_final  <= last_q;
            if (last_q) begin
              length <= '0;
              best   <= '0;
            end else begin
              best <= best_next;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign results.valid         = out_valid;
  assign results.window_length = out_win;
  assign results.best_length   = out_best;
  assign results.capped        = out_capped;
  assign results.is_final      = out_final;

  // The window never grows past the store depth.
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    length <= FULL_LEN)
    else $error("window length exceeds store depth");

  // Between items the best length covers the current window.
  a_best_cover: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (best >= length))
    else $error("best length below current window length");

  // Shrinking never works on an empty window.
  a_shrink_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHRINK) |-> (length != '0))
    else $error("shrink step with empty window");

  // A transfer into a full window is flagged as capped.
  a_capped_flag: assert property (@(posedge clk) disable iff (rst)
    (accept && full) |=> capped_q)
    else $error("full window transfer not flagged as capped");
endmodule

@@ test/lbrw_window_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for the longest bounded-range window block: predicts every result and compares.
// Watches the sample, result and register ports. Depends on lbrw_pkg, lbrw_in_if, lbrw_out_if.
module lbrw_window_checker (
  input  logic                            clk,
  input  logic                            rst,
  lbrw_in_if                              items,
  lbrw_out_if                             results,
  input  logic                            cfg_we,
  input  logic [lbrw_pkg::LIMIT_BITS-1:0] cfg_wdata,
  output int                              mismatch_count,
  output int                              pending_count
);
  localparam int DEPTH        = lbrw_pkg::DEFAULT_WINDOW_DEPTH;
  localparam int SBITS        = lbrw_pkg::DEFAULT_SAMPLE_BITS;
  localparam int FLEN         = lbrw_pkg::FIELD_LEN_BITS;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [FLEN-1:0] window_length;
    logic [FLEN-1:0] best_length;
    logic            capped;
    logic            is_final;
  } window_result_t;

  // Own copy of the block state: the window contents, oldest first.
  logic signed [SBITS-1:0]         window_samples[$];
  logic [FLEN-1:0]                 longest_window;
  logic [lbrw_pkg::LIMIT_BITS-1:0] span_limit;
  window_result_t                  expected_results[$];

  // Maximum minus minimum of the window, one bit wider than a sample so it cannot wrap.
  function automatic logic [SBITS:0] window_span();
    logic signed [SBITS-1:0] hi;
    logic signed [SBITS-1:0] lo;
    hi = window_samples[0];
    lo = window_samples[0];
    foreach (window_samples[i]) begin
      if (window_samples[i] > hi) hi = window_samples[i];
      if (window_samples[i] < lo) lo = window_samples[i];
    end
    return {hi[SBITS-1], hi} - {lo[SBITS-1], lo};
  endfunction

  // Advances the window by one sample and returns the result the block owes for it.
  function automatic window_result_t predict_window(input logic signed [SBITS-1:0] value,
                                                    input logic last);
    window_result_t r;
    r.capped = 1'b0;
    // A full store drops its oldest sample before the new one goes in.
    if (window_samples.size() >= DEPTH) begin
      void'(window_samples.pop_front());
      r.capped = 1'b1;
    end
    window_samples.push_back(value);
    // Shrink from the front while the span is too wide; one sample always stays.
    while (window_samples.size() > 1 && window_span() > {1'b0, span_limit})
      void'(window_samples.pop_front());
    if (window_samples.size() > longest_window)
      longest_window = FLEN'(window_samples.size());
    r.window_length = FLEN'(window_samples.size());
    r.best_length   = longest_window;
    r.is_final      = last;
    // The end of a sequence clears everything but the limit.
    if (last) begin
      window_samples.delete();
      longest_window = '0;
    end
    return r;
  endfunction

  // Track register writes, predict on each sample transfer, check each result transfer.
  always @(posedge clk) begin
    window_result_t got;
    window_result_t want;
    if (rst) begin
      window_samples.delete();
      expected_results.delete();
      longest_window = '0;
      span_limit     = '0;
      mismatch_count = 0;
    end else begin
      if (cfg_we) span_limit = cfg_wdata;
      if (items.valid && items.ready)
        expected_results.push_back(predict_window(items.sample, items.last));
      if (results.valid && results.ready) begin
        got.window_length = results.window_length;
        got.best_length   = results.best_length;
        got.capped        = results.capped;
        got.is_final      = results.is_final;
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: result with nothing expected: len=%0d best=%0d capped=%0b final=%0b",
                     $time, got.window_length, got.best_length, got.capped, got.is_final);
        end else begin
          want = expected_results.pop_front();
          if (got.window_length !== want.window_length || got.best_length !== want.best_length ||
              got.capped !== want.capped || got.is_final !== want.is_final) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
              $display({"%0t: mismatch, expected len=%0d best=%0d capped=%0b final=%0b,",
                        " got len=%0d best=%0d capped=%0b final=%0b"}, $time,
                       want.window_length, want.best_length, want.capped, want.is_final,
                       got.window_length, got.best_length, got.capped, got.is_final);
          end
        end
      end
    end
    pending_count = expected_results.size();
  end

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
// Testbench top for the longest bounded-range window block: clock, reset, stimulus and verdict.
// Depends on lbrw_pkg, lbrw_in_if, lbrw_out_if, the block itself and lbrw_window_checker.
module tb;
  localparam int DEPTH         = lbrw_pkg::DEFAULT_WINDOW_DEPTH;
  localparam int SBITS         = lbrw_pkg::DEFAULT_SAMPLE_BITS;
  localparam int LBITS         = lbrw_pkg::LIMIT_BITS;
  localparam int PHASE_SAMPLES = 10;
  localparam int HOLD_CYCLES   = 300;
  localparam int QUIET_LIMIT   = 20000;
  localparam int DRAIN_CYCLES  = 40;

  typedef logic signed [SBITS-1:0] sample_t;

  localparam sample_t SAMPLE_MIN = {1'b1, {(SBITS-1){1'b0}}};
  localparam sample_t SAMPLE_MAX = ~SAMPLE_MIN;
  localparam logic [LBITS-1:0] LIMIT_MAX = '1;

  // Shapes of generated sequences.
  typedef enum int {
    SEQ_CLUSTER,
    SEQ_FULL,
    SEQ_EXTREME,
    SEQ_RAMP_UP,
    SEQ_RAMP_DOWN
  } seq_kind_t;

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [LBITS-1:0] cfg_wdata;
  int               mismatch_count;
  int               pending_count;
  int               send_idle_pct;
  int               recv_idle_pct;
  bit               hold_request;
  int               sample_total;
  int               sequence_total;
  int               limit_total;

  lbrw_in_if  items ();
  lbrw_out_if results ();

  longest_bounded_range_window dut (
    .clk       (clk),
    .rst       (rst),
    .items     (items),
    .results   (results),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  lbrw_window_checker window_check (
    .clk            (clk),
    .rst            (rst),
    .items          (items),
    .results        (results),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count)
  );

  // 10 ns clock.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Watchdog: end the run when nothing has been transferred for too long.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (items.valid && items.ready) || (results.valid && results.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("longest_bounded_range_window verification failed");
    $finish;
  end

  // Result side: random stalls, plus one long hold-off when requested.
  initial begin
    bit hold_done;
    hold_done     = 1'b0;
    results.ready = 1'b0;
    wait (rst == 1'b0);
    forever begin
      @(negedge clk);
      if (hold_request && !hold_done) begin
        results.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end
      results.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Offers one sample, with a random gap first, and returns at the falling edge after the transfer.
  task automatic push_sample(input sample_t value, input logic is_last);
    while ($urandom_range(99) < send_idle_pct) begin
      items.valid <= 1'b0;
      @(negedge clk);
    end
    items.valid  <= 1'b1;
    items.sample <= value;
    items.last   <= is_last;
    do @(posedge clk); while (!items.ready);
    @(negedge clk);
    sample_total++;
    if (is_last) sequence_total++;
  endtask

  // Waits until every sample sent has produced its result.
  task automatic settle();
    items.valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Writes the span limit once the block is idle.
  task automatic set_limit(input logic [LBITS-1:0] value);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    limit_total++;
  endtask

  function automatic sample_t pick_sample(input seq_kind_t kind, input sample_t base,
                                          input int unsigned idx, input int unsigned spread);
    case (kind)
      SEQ_CLUSTER:   return base + sample_t'($urandom_range(spread));
      SEQ_FULL:      return sample_t'($urandom());
      SEQ_RAMP_UP:   return base + sample_t'(idx * spread);
      SEQ_RAMP_DOWN: return base - sample_t'(idx * spread);
      SEQ_EXTREME: begin
        case ($urandom_range(5))
          0: return SAMPLE_MIN;
          1: return SAMPLE_MAX;
          2: return -1;
          3: return 0;
          4: return 1;
          default: return sample_t'($urandom());
        endcase
      end
      default: return '0;
    endcase
  endfunction

  // One sequence of the given shape; the final sample carries the last flag.
  task automatic send_sequence(input seq_kind_t kind, input int len);
    sample_t     base;
    int unsigned spread;
    base   = sample_t'($urandom());
    spread = ($urandom_range(3) == 0) ? $urandom_range(2) : $urandom_range(64);
    for (int i = 0; i < len; i++)
      push_sample(pick_sample(kind, base, i, spread), i == len - 1);
  endtask

  // One limit setting followed by a batch of random sequences, mostly short.
  task automatic run_phase(input logic [LBITS-1:0] limit);
    int        budget;
    int        len;
    seq_kind_t kind;
    set_limit(limit);
    budget = PHASE_SAMPLES;
    while (budget > 0) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 12);
      case ($urandom_range(9))
        0, 1, 2, 3, 9: kind = SEQ_CLUSTER;
        4, 5:          kind = SEQ_FULL;
        6:             kind = SEQ_EXTREME;
        7:             kind = SEQ_RAMP_UP;
        default:       kind = SEQ_RAMP_DOWN;
      endcase
      send_sequence(kind, len);
      budget -= len;
    end
  endtask

  // Reset, directed cases, random phases under three idle mixes, then a full-store run.
  initial begin
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    items.valid    = 1'b0;
    items.sample   = '0;
    items.last     = 1'b0;
    hold_request   = 1'b0;
    send_idle_pct  = 15;
    recv_idle_pct  = 63;
    sample_total   = 0;
    sequence_total = 0;
    limit_total    = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Zero limit: only runs of equal values grow; a lone sample is a sequence of its own.
    set_limit('0);
    push_sample(5, 1'b0);
    push_sample(5, 1'b0);
    push_sample(5, 1'b0);
    push_sample(7, 1'b0);
    push_sample(7, 1'b1);
    push_sample(-1, 1'b1);

    // Widest span exactly at the largest limit, then one short of it.
    set_limit(LIMIT_MAX);
    push_sample(SAMPLE_MIN, 1'b0);
    push_sample(SAMPLE_MAX, 1'b0);
    push_sample(0, 1'b1);
    set_limit(LIMIT_MAX - 1);
    push_sample(SAMPLE_MAX, 1'b0);
    push_sample(SAMPLE_MIN, 1'b0);
    push_sample(SAMPLE_MIN, 1'b1);

    // Small limit with values that pop both running extremes.
    set_limit(3);
    push_sample(10, 1'b0);
    push_sample(12, 1'b0);
    push_sample(9, 1'b0);
    push_sample(13, 1'b0);
    push_sample(11, 1'b0);
    push_sample(11, 1'b0);
    push_sample(20, 1'b1);

    // Random phases: receiver-heavy idling, sender-heavy idling, then none.
    for (int mix = 0; mix < 3; mix++) begin
      send_idle_pct = (mix == 0) ? 15 : (mix == 1) ? 63 : 0;
      recv_idle_pct = (mix == 0) ? 63 : (mix == 1) ? 15 : 0;
      run_phase('0);
      run_phase($urandom_range(1, 40));
      run_phase($urandom());
      run_phase(LIMIT_MAX);
    end

    // Fill the store past its depth while the result side holds off for a long stretch.
    set_limit(LIMIT_MAX);
    hold_request = 1'b1;
    send_sequence(SEQ_FULL, DEPTH + 8);
    settle();
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Run covered %0d samples in %0d sequences across %0d span limit settings.",
             sample_total, sequence_total, limit_total);
    $display("It included three idle mixes and a %0d-sample full-store sequence %s",
             DEPTH + 8, "under back-pressure.");
    if (mismatch_count == 0 && pending_count == 0)
      $display("longest_bounded_range_window verification clean");
    else
      $display("longest_bounded_range_window verification failed");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/lbrw_pkg.sv
rtl/core/lbrw_in_if.sv
rtl/core/lbrw_out_if.sv
rtl/core/lbrw_cell.sv
rtl/core/lbrw_chain.sv
rtl/core/longest_bounded_range_window.sv
test/lbrw_window_checker.sv
test/tb.sv
